@@ rtl/itra_pkg.sv @@
// shared constants, types and functions for the integer to radix ascii block
`timescale 1ns / 1ps

package itra_pkg;

  // default width of the converted value
  localparam int VALUE_BITS_DEF = 32;

  // radix register and digit widths
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = RADIX_W;

  // register index decoded from paddr[2]
  localparam logic REG_RADIX = 1'b0;

  // radix codes with special handling
  localparam logic [RADIX_W-1:0] RADIX_BIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // ascii codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_BIN     = 8'h62;
  localparam logic [7:0] CH_DEC     = 8'h64;
  localparam logic [7:0] CH_HEX     = 8'h78;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ALPHA   = 8'h41;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // control handed from the sequencer to the digit chain
  typedef struct packed {
    logic               clear;
    logic               shift;
    logic [RADIX_W-1:0] radix;
  } chain_ctrl_t;

  // digit value to its ascii character
  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] d8;
    d8 = {{(8-DIGIT_W){1'b0}}, d};
    if (d8 < 8'd10) begin
      digit_char = CH_ZERO + d8;
    end else begin
      digit_char = CH_ALPHA + d8 - 8'd10;
    end
  endfunction

endpackage

@@ rtl/itra_cell.sv @@
// one digit cell: doubles its digit plus incoming bit modulo the radix
`timescale 1ns / 1ps

module itra_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  itra_pkg::chain_ctrl_t          ctrl,
  input  logic                           carry_in,
  input  logic                           valid_in,
  input  logic [itra_pkg::DIGIT_W-1:0]   digit_in,
  output logic                           carry_out,
  output logic                           valid_out,
  output logic [itra_pkg::DIGIT_W-1:0]   digit
);

  logic [itra_pkg::DIGIT_W:0] dbl;
  logic                       wrap;

  // twice the digit plus the bit from the lower neighbour
  assign dbl  = {digit, carry_in};
  assign wrap = dbl >= {1'b0, ctrl.radix};

  // digit, carry and token registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
      carry_out <= 1'b0;
      digit     <= '0;
    end else if (ctrl.clear) begin
      valid_out <= 1'b0;
      carry_out <= 1'b0;
      digit     <= '0;
    end else if (ctrl.shift) begin
      valid_out <= 1'b0;
      digit     <= digit_in;
    end else begin
      valid_out <= valid_in;
      if (valid_in) begin
        carry_out <= wrap;
        if (wrap) begin
          digit <= itra_pkg::DIGIT_W'(dbl - {1'b0, ctrl.radix});
        end else begin
          digit <= dbl[itra_pkg::DIGIT_W-1:0];
        end
      end
    end
  end

endmodule

@@ rtl/itra_chain.sv @@
// row of digit cells, least significant at index 0
`timescale 1ns / 1ps

module itra_chain #(
  parameter int NCELLS = itra_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  itra_pkg::chain_ctrl_t        ctrl,
  input  logic                         bit_in,
  input  logic                         bit_valid,
  output logic [itra_pkg::DIGIT_W-1:0] top_digit
);

  logic                         carry [NCELLS+1];
  logic                         valid [NCELLS+1];
  logic [itra_pkg::DIGIT_W-1:0] dig   [NCELLS+1];

  // the value's bits enter the least significant cell, zeros shift in below
  assign carry[0] = bit_in;
  assign valid[0] = bit_valid;
  assign dig[0]   = '0;

  // cell i feeds carries up to cell i+1 and receives digits from cell i-1
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    itra_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .carry_in  (carry[i]),
      .valid_in  (valid[i]),
      .digit_in  (dig[i]),
      .carry_out (carry[i+1]),
      .valid_out (valid[i+1]),
      .digit     (dig[i+1])
    );
  end

  assign top_digit = dig[NCELLS];

endmodule

@@ rtl/integer_to_radix_ascii.sv @@
// integer to radix ascii converter: sequencer, config register and output stage
//
// A request on the input channel (in_valid/in_ready, value) carries one
// signed integer. The block answers with a run of ascii characters on the
// output channel (out_valid/out_ready, character, last): '0', a prefix
// ('b', 'd' or 'x'), '-' for negatives, the digits most significant first
// and a newline flagged by last. Radix 8 gives only '0' and the newline;
// a radix below 2 consumes the request and gives nothing.
// The radix register sits at byte address 0 of the APB port, reset to 10.
// Conversion runs the magnitude's bits through a row of VALUE_BITS digit
// cells, one bit per cycle, with the carry and token registered in each
// cell. The first character is loaded once conversion is done; then come
// the prefix and sign, the digits after leading zero skipping, and the
// newline. in_ready is high only while no request is in progress, so a new
// request is taken only once the last one has finished. A stalled receiver
// holds the output register and the sequencer waits before each character.
// Reset returns to idle, drops any pending character and restores the
// radix.
`timescale 1ns / 1ps

module integer_to_radix_ascii #(
  parameter int VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  // output channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            character,
  output logic                  last
);

  localparam int NCELLS  = VALUE_BITS;
  localparam int CONV_N  = VALUE_BITS + NCELLS;
  localparam int CNT_W   = $clog2(CONV_N);
  localparam int REM_W   = $clog2(NCELLS + 1);
  localparam int RADIX_W = itra_pkg::RADIX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_ZERO, S_PREFIX, S_SIGN, S_SKIP, S_DIGIT, S_NL
  } state_t;

  state_t                        state;
  logic [RADIX_W-1:0]            radix;
  logic [RADIX_W-1:0]            rad_q;
  logic [VALUE_BITS-1:0]         mag;
  logic                          neg;
  logic [CNT_W-1:0]              conv_cnt;
  logic [REM_W-1:0]              remaining;
  logic                          accept;
  logic                          can_load;
  logic                          emit;
  logic                          more_lead;
  logic [itra_pkg::DIGIT_W-1:0]  top_digit;
  itra_pkg::chain_ctrl_t         ctrl;

  // apb register access
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == itra_pkg::REG_RADIX) begin
      prdata = {{(32-RADIX_W){1'b0}}, radix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itra_pkg::RADIX_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == itra_pkg::REG_RADIX) begin
      radix <= pwdata[RADIX_W-1:0];
    end
  end

  // handshake helpers
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign can_load  = !out_valid || out_ready;
  assign more_lead = (top_digit == '0) && (remaining > REM_W'(1));
  assign emit      = can_load && (state == S_ZERO || state == S_PREFIX ||
                                  state == S_SIGN || state == S_DIGIT || state == S_NL);

  // chain control
  always_comb begin
    ctrl.clear = accept;
    ctrl.radix = rad_q;
    ctrl.shift = (state == S_SKIP && more_lead) || (state == S_DIGIT && can_load);
  end

  itra_chain #(
    .NCELLS (NCELLS)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .bit_in    (mag[VALUE_BITS-1]),
    .bit_valid (state == S_CONV && conv_cnt < CNT_W'(VALUE_BITS)),
    .top_digit (top_digit)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      last      <= 1'b0;
      character <= '0;
      conv_cnt  <= '0;
      remaining <= '0;
      rad_q     <= itra_pkg::RADIX_RESET;
      neg       <= 1'b0;
      mag       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && radix >= itra_pkg::RADIX_MIN) begin
            rad_q     <= radix;
            neg       <= value[VALUE_BITS-1];
            mag       <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
            conv_cnt  <= '0;
            remaining <= REM_W'(NCELLS);
            state     <= S_CONV;
          end
        end
        S_CONV: begin
          mag      <= {mag[VALUE_BITS-2:0], 1'b0};
          conv_cnt <= conv_cnt + 1'b1;
          if (conv_cnt == CNT_W'(CONV_N - 1)) begin
            state <= S_ZERO;
          end
        end
        S_ZERO: begin
          if (can_load) begin
            character <= itra_pkg::CH_ZERO;
            last      <= 1'b0;
            state     <= (rad_q == itra_pkg::RADIX_OCT) ? S_NL : S_PREFIX;
          end
        end
        S_PREFIX: begin
          if (can_load) begin
            last      <= 1'b0;
            if (rad_q == itra_pkg::RADIX_BIN) begin
              character <= itra_pkg::CH_BIN;
            end else if (rad_q == itra_pkg::RADIX_DEC) begin
              character <= itra_pkg::CH_DEC;
            end else begin
              character <= itra_pkg::CH_HEX;
            end
            state <= neg ? S_SIGN : S_SKIP;
          end
        end
        S_SIGN: begin
          if (can_load) begin
            character <= itra_pkg::CH_MINUS;
            last      <= 1'b0;
            state     <= S_SKIP;
          end
        end
        S_SKIP: begin
          // drop leading zero digits, keeping at least one
          if (more_lead) begin
            remaining <= remaining - 1'b1;
          end else begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (can_load) begin
            character <= itra_pkg::digit_char(top_digit);
            last      <= 1'b0;
            remaining <= remaining - 1'b1;
            if (remaining == REM_W'(1)) begin
              state <= S_NL;
            end
          end
        end
        S_NL: begin
          if (can_load) begin
            character <= itra_pkg::CH_NEWLINE;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ test/integer_to_radix_ascii_tb.sv @@
// testbench for the integer to radix ascii converter: directed table, random phases, self-check
`timescale 1ns / 1ps

module integer_to_radix_ascii_tb;

  localparam int W = itra_pkg::VALUE_BITS_DEF;
  localparam int RW = itra_pkg::RADIX_W;
  // idle wait before a radix write and at the end, with margin over the worst conversion plus emission
  localparam int SETTLE_CYCLES = 200;
  localparam int ITEM_TARGET = 96;
  localparam int QUIET_FROM = 80;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } out_char_t;

  typedef struct {
    logic [RW-1:0] radix;
    logic [W-1:0]  val;
    bit            typed;
    string         text;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [W-1:0]       value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         character;
  logic               last;

  out_char_t          pending_chars[$];
  logic [RW-1:0]      cur_radix = itra_pkg::RADIX_RESET;
  int                 n_mismatch = 0;
  int                 gap_pct = 20;
  int                 stall_pct = 20;
  bit                 quiet = 1'b0;
  dir_row_t           dir_rows[$];

  integer_to_radix_ascii #(.VALUE_BITS(W)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .character(character), .last(last)
  );

  always #1 clk = ~clk;

  // expected character run for one value at the given radix
  function automatic void predict_chars(input logic [RW-1:0] rdx, input logic [W-1:0] v);
    logic [W-1:0] mag;
    logic [7:0]   d8;
    logic [7:0]   digs[$];
    if (rdx < itra_pkg::RADIX_MIN) return;
    pending_chars.push_back('{itra_pkg::CH_ZERO, 1'b0});
    if (rdx != itra_pkg::RADIX_OCT) begin
      if (rdx == itra_pkg::RADIX_BIN) begin
        pending_chars.push_back('{itra_pkg::CH_BIN, 1'b0});
      end else if (rdx == itra_pkg::RADIX_DEC) begin
        pending_chars.push_back('{itra_pkg::CH_DEC, 1'b0});
      end else begin
        pending_chars.push_back('{itra_pkg::CH_HEX, 1'b0});
      end
      // magnitude; the most negative value wraps onto its unsigned self
      if (v[W-1]) begin
        pending_chars.push_back('{itra_pkg::CH_MINUS, 1'b0});
        mag = -v;
      end else begin
        mag = v;
      end
      do begin
        d8 = 8'(mag % W'(rdx));
        digs.push_front(d8 < 8'd10 ? itra_pkg::CH_ZERO + d8
                                   : itra_pkg::CH_ALPHA + d8 - 8'd10);
        mag = mag / W'(rdx);
      end while (mag != 0);
      foreach (digs[i]) pending_chars.push_back('{digs[i], 1'b0});
    end
    pending_chars.push_back('{itra_pkg::CH_NEWLINE, 1'b1});
  endfunction

  function automatic dir_row_t row(input logic [RW-1:0] r, input logic [W-1:0] v,
                                   input bit typed, input string text);
    dir_row_t x;
    x.radix = r;
    x.val = v;
    x.typed = typed;
    x.text = text;
    return x;
  endfunction

  function automatic logic [W-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return W'($urandom_range(0, 40));
      1: return -W'($urandom_range(1, 40));
      2: return $urandom_range(0, 1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      3: return W'($urandom) >> $urandom_range(0, W-1);
      default: return W'($urandom);
    endcase
  endfunction

  function automatic logic [RW-1:0] random_radix();
    case ($urandom_range(0, 9))
      0: return itra_pkg::RADIX_BIN;
      1: return itra_pkg::RADIX_DEC;
      2: return 6'd16;
      3: return itra_pkg::RADIX_OCT;
      4: return RW'($urandom_range(0, 1));
      5: return RW'($urandom_range(37, 63));
      default: return RW'($urandom_range(2, 36));
    endcase
  endfunction

  // radix write over apb, only once the block has gone idle
  task automatic write_radix(input logic [RW-1:0] r);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {itra_pkg::REG_RADIX, 2'b00};
    pwdata <= {{(32-RW){1'b0}}, r};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    cur_radix = r;
  endtask

  // one request on the input channel, with an optional idle burst first
  task automatic send_value(input logic [W-1:0] v, input bit typed, input string text);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      value <= W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      for (int i = 0; i < text.len(); i++) begin
        pending_chars.push_back('{8'(text[i]), i == text.len() - 1});
      end
    end else begin
      predict_chars(cur_radix, v);
    end
  endtask

  // receiver: ready with random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0 && !quiet) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = 0;
        if (!quiet && $urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 13);
      end
    end
  end

  // compare each accepted character with the oldest expectation
  always @(posedge clk) begin
    out_char_t exp_c;
    if (!rst && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected character %h last %b with no request pending", character, last);
      end else begin
        exp_c = pending_chars.pop_front();
        if (character !== exp_c.ch || last !== exp_c.lst) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch at radix %0d: expected %h last %b, got %h last %b",
                     cur_radix, exp_c.ch, exp_c.lst, character, last);
        end
      end
    end
  end

  // stimulus
  initial begin
    int counted;
    int n;
    logic [RW-1:0] rdx;
    counted = 0;
    dir_rows.push_back(row(6'd10, 32'h0000_0000, 1, "0d0\n"));
    dir_rows.push_back(row(6'd10, 32'h7FFF_FFFF, 1, "0d2147483647\n"));
    dir_rows.push_back(row(6'd10, 32'h8000_0000, 1, "0d-2147483648\n"));
    dir_rows.push_back(row(6'd10, 32'hFFFF_FFFF, 1, "0d-1\n"));
    dir_rows.push_back(row(6'd10, 32'd12345, 0, ""));
    dir_rows.push_back(row(6'd2, 32'h0000_0000, 1, "0b0\n"));
    dir_rows.push_back(row(6'd2, 32'd5, 1, "0b101\n"));
    dir_rows.push_back(row(6'd2, 32'h8000_0000, 0, ""));
    dir_rows.push_back(row(6'd2, 32'h7FFF_FFFF, 0, ""));
    dir_rows.push_back(row(6'd8, 32'hFFFF_FFFF, 1, "0\n"));
    dir_rows.push_back(row(6'd8, 32'd123, 1, "0\n"));
    dir_rows.push_back(row(6'd16, 32'hFFFF_FFFF, 1, "0x-1\n"));
    dir_rows.push_back(row(6'd16, 32'h7FFF_FFFF, 1, "0x7FFFFFFF\n"));
    dir_rows.push_back(row(6'd16, 32'h8000_0000, 1, "0x-80000000\n"));
    dir_rows.push_back(row(6'd16, 32'h0ABC_DEF0, 0, ""));
    dir_rows.push_back(row(6'd36, 32'd35, 1, "0xZ\n"));
    dir_rows.push_back(row(6'd36, 32'h8000_0000, 0, ""));
    // digits past 'Z' run on into the following ascii codes
    dir_rows.push_back(row(6'd37, 32'd36, 1, "0x[\n"));
    dir_rows.push_back(row(6'd63, 32'd62, 1, "0xu\n"));
    dir_rows.push_back(row(6'd63, 32'h7FFF_FFFF, 0, ""));
    // invalid base swallows the request
    dir_rows.push_back(row(6'd0, 32'd55, 1, ""));
    dir_rows.push_back(row(6'd1, 32'hFFFF_FFF9, 1, ""));
    dir_rows.push_back(row(6'd3, 32'hFFFF_FF9C, 0, ""));
    dir_rows.push_back(row(6'd10, 32'h5555_AAAA, 0, ""));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].radix != cur_radix) write_radix(dir_rows[i].radix);
      send_value(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].text);
    end

    // random phases, each at its own radix and idling mix
    while (counted < ITEM_TARGET) begin
      rdx = random_radix();
      write_radix(rdx);
      gap_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
      stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
      n = $urandom_range(6, 14);
      repeat (n) begin
        if (counted >= QUIET_FROM) quiet = 1'b1;
        send_value(random_value(), 0, "");
        counted++;
      end
    end
    in_valid <= 1'b0;

    // drain and let the block settle
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_mismatch == 0 && pending_chars.size() == 0) begin
      $display("integer_to_radix_ascii_tb passed");
    end else begin
      $display("integer_to_radix_ascii_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("integer_to_radix_ascii_tb failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/itra_pkg.sv
rtl/itra_cell.sv
rtl/itra_chain.sv
rtl/integer_to_radix_ascii.sv
test/integer_to_radix_ascii_tb.sv
